// ===== rtl/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared widths and the side-band record carried down the reflection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrd_pkg;

  // core operand width after the input pre-shift
  localparam int CORE_W = 16;
  // product of two core operands
  localparam int PROD_W = 2 * CORE_W;
  // d.n holds three signed products
  localparam int DN_W   = PROD_W + 2;
  // n.n holds three non-negative products
  localparam int NN_W   = PROD_W;
  // d * (n.n) and (d.n) * n
  localparam int A_W    = CORE_W + NN_W + 1;
  localparam int B_W    = DN_W + CORE_W;
  // unreduced reflection vector component
  localparam int R_W    = 52;
  localparam int RMAG_W = R_W - 1;
  // reduced magnitude, square and sum of squares
  localparam int MAG_W  = 30;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  // right shift that brings the biggest magnitude below 2^MAG_W
  localparam int SH_W   = 5;

  // per-item record that rides alongside the length computation
  typedef struct packed {
    logic [2:0]             neg;
    logic                   degen;
    logic [2:0][MAG_W-1:0]  mag;
  } side_t;

endpackage

// ===== rtl/rrd_front.sv =====
// ----------------------------------------------------------------------------
// rrd_front
// Dot products, unreduced reflection vector, magnitude reduction and the sum
// of squares, eight register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrd_front #(
  parameter int IN_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [2:0][IN_WIDTH-1:0]               dir,
  input  logic [2:0][IN_WIDTH-1:0]               nrm,
  output logic                                   out_valid,
  output rrd_pkg::side_t                         out_side,
  output logic [rrd_pkg::SUM_W-1:0]              out_sum
);

  localparam int CW  = rrd_pkg::CORE_W;
  localparam int PRE = (IN_WIDTH > CW) ? (IN_WIDTH - CW) : 0;
  localparam int EW  = IN_WIDTH + CW;

  logic [7:0] v_r;

  // stage registers
  logic signed [2:0][CW-1:0]               d1_r, n1_r, d2_r, n2_r;
  logic signed [2:0][rrd_pkg::PROD_W-1:0]  pdn1_r;
  logic        [2:0][rrd_pkg::PROD_W-1:0]  pnn1_r;
  logic signed [rrd_pkg::DN_W-1:0]         dn2_r;
  logic        [rrd_pkg::NN_W-1:0]         nn2_r;
  logic signed [2:0][rrd_pkg::A_W-1:0]     a3_r;
  logic signed [2:0][rrd_pkg::B_W-1:0]     b3_r;
  logic                                    nz3_r, nz4_r;
  logic signed [2:0][rrd_pkg::R_W-1:0]     r4_r;
  logic        [2:0][rrd_pkg::RMAG_W-1:0]  m5_r;
  logic        [2:0]                       neg5_r;
  logic                                    dg5_r;
  logic        [rrd_pkg::SH_W-1:0]         sh5_r;
  rrd_pkg::side_t                          s6_r, s7_r, s8_r;
  logic        [2:0][rrd_pkg::SQ_W-1:0]    sq7_r;
  logic        [rrd_pkg::SUM_W-1:0]        sum8_r;

  logic signed [2:0][CW-1:0]               d_ld, n_ld;
  logic signed [2:0][rrd_pkg::R_W-1:0]     r_nxt;
  logic        [2:0][rrd_pkg::RMAG_W-1:0]  m_nxt;
  logic        [rrd_pkg::RMAG_W-1:0]       orv;
  logic        [rrd_pkg::SH_W-1:0]         sh_nxt;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  // input load: sign-extend and floor-shift wide fields to core width
  always_comb begin
    logic signed [EW-1:0] ed, en_;
    for (int i = 0; i < 3; i++) begin
      ed       = EW'($signed(dir[i]));
      en_      = EW'($signed(nrm[i]));
      ed       = ed >>> PRE;
      en_      = en_ >>> PRE;
      d_ld[i]  = ed[CW-1:0];
      n_ld[i]  = en_[CW-1:0];
    end
  end

  // reflection vector r = d*(n.n) - 2*(d.n)*n
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_nxt[i] = rrd_pkg::R_W'($signed(a3_r[i]))
               - (rrd_pkg::R_W'($signed(b3_r[i])) <<< 1);
    end
  end

  // magnitudes and the reduction shift from the top set bit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_nxt[i] = r4_r[i][rrd_pkg::R_W-1] ? rrd_pkg::RMAG_W'(-r4_r[i])
                                         : rrd_pkg::RMAG_W'(r4_r[i]);
    end
    orv    = m_nxt[0] | m_nxt[1] | m_nxt[2];
    sh_nxt = '0;
    for (int k = rrd_pkg::MAG_W; k < rrd_pkg::RMAG_W; k++) begin
      if (orv[k]) begin
        sh_nxt = rrd_pkg::SH_W'(k - rrd_pkg::MAG_W + 1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]   <= d_ld[i];
        n1_r[i]   <= n_ld[i];
        pdn1_r[i] <= rrd_pkg::PROD_W'($signed(d_ld[i]))
                   * rrd_pkg::PROD_W'($signed(n_ld[i]));
        pnn1_r[i] <= rrd_pkg::PROD_W'($signed(n_ld[i]))
                   * rrd_pkg::PROD_W'($signed(n_ld[i]));
      end
      d2_r  <= d1_r;
      n2_r  <= n1_r;
      dn2_r <= rrd_pkg::DN_W'($signed(pdn1_r[0])) + rrd_pkg::DN_W'($signed(pdn1_r[1]))
             + rrd_pkg::DN_W'($signed(pdn1_r[2]));
      nn2_r <= pnn1_r[0] + pnn1_r[1] + pnn1_r[2];
      for (int i = 0; i < 3; i++) begin
        a3_r[i] <= rrd_pkg::A_W'($signed(d2_r[i]))
                 * rrd_pkg::A_W'($signed({1'b0, nn2_r}));
        b3_r[i] <= rrd_pkg::B_W'(dn2_r) * rrd_pkg::B_W'($signed(n2_r[i]));
      end
      nz3_r  <= (nn2_r == '0);
      r4_r   <= r_nxt;
      nz4_r  <= nz3_r;
      m5_r   <= m_nxt;
      for (int i = 0; i < 3; i++) begin
        neg5_r[i] <= r4_r[i][rrd_pkg::R_W-1];
      end
      dg5_r  <= nz4_r || (orv == '0);
      sh5_r  <= sh_nxt;
      s6_r.neg   <= neg5_r;
      s6_r.degen <= dg5_r;
      for (int i = 0; i < 3; i++) begin
        s6_r.mag[i] <= rrd_pkg::MAG_W'(m5_r[i] >> sh5_r);
      end
      s7_r <= s6_r;
      for (int i = 0; i < 3; i++) begin
        sq7_r[i] <= rrd_pkg::SQ_W'(s6_r.mag[i]) * rrd_pkg::SQ_W'(s6_r.mag[i]);
      end
      s8_r   <= s7_r;
      sum8_r <= rrd_pkg::SUM_W'(sq7_r[0]) + rrd_pkg::SUM_W'(sq7_r[1])
              + rrd_pkg::SUM_W'(sq7_r[2]);
    end
  end

  assign out_valid = v_r[7];
  assign out_side  = s8_r;
  assign out_sum   = sum8_r;

endmodule

// ===== rtl/rrd_isqrt.sv =====
// ----------------------------------------------------------------------------
// rrd_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrd_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  rrd_pkg::side_t               in_side,
  input  logic [rrd_pkg::SUM_W-1:0]    in_sum,
  output logic                         out_valid,
  output rrd_pkg::side_t               out_side,
  output logic [rrd_pkg::ROOT_W-1:0]   out_root
);

  localparam int N     = rrd_pkg::ROOT_W;
  localparam int REM_W = rrd_pkg::ROOT_W + 4;
  localparam int SW    = rrd_pkg::SUM_W;

  logic                 v_r    [0:N-1];
  rrd_pkg::side_t       side_r [0:N-1];
  logic [REM_W-1:0]     rem_r  [0:N-1];
  logic [N-1:0]         root_r [0:N-1];
  logic [SW-1:0]        rad_r  [0:N-1];

  for (genvar g = 0; g < N; g++) begin : g_step
    logic                 v_p;
    rrd_pkg::side_t       side_p;
    logic [REM_W-1:0]     rem_p, rem_sh, trial;
    logic [N-1:0]         root_p;
    logic [SW-1:0]        rad_p;
    logic                 ge;

    // previous stage, or the stage input for the first step
    if (g == 0) begin : g_first
      assign v_p    = in_valid;
      assign side_p = in_side;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_sum;
    end else begin : g_next
      assign v_p    = v_r[g-1];
      assign side_p = side_r[g-1];
      assign rem_p  = rem_r[g-1];
      assign root_p = root_r[g-1];
      assign rad_p  = rad_r[g-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_p[REM_W-3:0], rad_p[SW-1:SW-2]};
    assign trial  = {{(REM_W-N-2){1'b0}}, root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= side_p;
        rem_r[g]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[g] <= {root_p[N-2:0], ge};
        rad_r[g]  <= {rad_p[SW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_side  = side_r[N-1];
  assign out_root  = root_r[N-1];

endmodule

// ===== rtl/rrd_div.sv =====
// ----------------------------------------------------------------------------
// rrd_div
// Three-lane pipelined restoring divider giving the rounded unit components,
// followed by the sign, degenerate forcing and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrd_div #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  rrd_pkg::side_t                     in_side,
  input  logic [rrd_pkg::ROOT_W-1:0]         in_root,
  output logic                               out_valid,
  output logic signed [2:0][OUT_FRAC_BITS+1:0] out_refl,
  output logic                               out_degen
);

  localparam int F     = OUT_FRAC_BITS;
  localparam int QW    = F + 1;
  localparam int OW    = F + 2;
  localparam int MW    = rrd_pkg::MAG_W;
  localparam int LW    = rrd_pkg::ROOT_W;
  localparam int NUM_W = MW + F + 1;
  localparam int RW    = LW + 1;

  logic                    v_r    [0:QW];
  rrd_pkg::side_t          side_r [0:QW];
  logic [LW-1:0]           den_r  [0:QW];
  logic [2:0][RW-1:0]      rem_r  [0:QW];
  logic [2:0][QW-1:0]      low_r  [0:QW];
  logic [2:0][QW-1:0]      q_r    [0:QW];

  logic                    vo_r;
  logic signed [2:0][OW-1:0] refl_r;
  logic                    dg_r;

  logic [2:0][NUM_W-1:0]   num;

  // numerator (mag << F) + floor(L/2); the quotient fits in F+1 bits,
  // so the upper part already sits below the divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUM_W'(in_side.mag[i]) << F) + NUM_W'(in_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      den_r[0]  <= in_root;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= RW'(num[i][NUM_W-1:QW]);
        low_r[0][i] <= num[i][QW-1:0];
        q_r[0][i]   <= '0;
      end
    end
  end

  // one quotient bit per stage in each lane
  for (genvar g = 1; g <= QW; g++) begin : g_step
    logic [2:0][RW-1:0] rem_sh;
    logic [2:0]         ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_sh[i] = {rem_r[g-1][i][RW-2:0], low_r[g-1][i][QW-1]};
        ge[i]     = (rem_sh[i] >= RW'(den_r[g-1]));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= side_r[g-1];
        den_r[g]  <= den_r[g-1];
        for (int i = 0; i < 3; i++) begin
          rem_r[g][i] <= ge[i] ? (rem_sh[i] - RW'(den_r[g-1])) : rem_sh[i];
          low_r[g][i] <= {low_r[g-1][i][QW-2:0], 1'b0};
          q_r[g][i]   <= {q_r[g-1][i][QW-2:0], ge[i]};
        end
      end
    end
  end

  // output register: sign, zero on a degenerate item; |q| <= 2^F always fits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg_r <= side_r[QW].degen;
      for (int i = 0; i < 3; i++) begin
        if (side_r[QW].degen) begin
          refl_r[i] <= '0;
        end else if (side_r[QW].neg[i]) begin
          refl_r[i] <= -$signed(OW'(q_r[QW][i]));
        end else begin
          refl_r[i] <= $signed(OW'(q_r[QW][i]));
        end
      end
    end
  end

  assign out_valid = vo_r;
  assign out_refl  = refl_r;
  assign out_degen = dg_r;

endmodule

// ===== rtl/ray_reflection_direction_core.sv =====
// ----------------------------------------------------------------------------
// ray_reflection_direction_core
// Specular reflection of a ray about a surface normal, given as a unit vector.
// ----------------------------------------------------------------------------
// Usage: one stream in, one stream out. An input item on in_* carries the
// incident direction and the surface normal, six signed IN_WIDTH fields. Each
// item gives exactly one result on out_*: the reflected direction scaled to
// unit length in signed Q1.OUT_FRAC_BITS, with out_tuser flagging a zero
// normal or a zero reflection (components then zero).
// Throughput: one item per cycle, sustained while out_tready is high.
// Pipeline: 8 front stages (dot products, reflection, reduction, sum of
// squares), 31 square-root stages, OUT_FRAC_BITS + 2 divider stages and the
// output register lie between acceptance and out_tvalid.
// Stall: the whole pipeline moves on a common enable; while a result waits
// on out_tready low, in_tready drops and every stage holds its item. Bubbles
// travel freely, so in_tready stays high while out_tvalid is low.
// Reset: rst_n low empties the pipeline; no item is held afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_reflection_direction_core #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, then zero padding
  input  logic [((6*IN_WIDTH+7)/8)*8-1:0]      in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // refl_x, refl_y, refl_z, then zero padding
  output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  // degenerate
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  localparam int OW    = OUT_FRAC_BITS + 2;

  logic                            en;
  logic [2:0][IN_WIDTH-1:0]        dir, nrm;
  logic                            f_valid, s_valid, d_valid;
  rrd_pkg::side_t                  f_side, s_side;
  logic [rrd_pkg::SUM_W-1:0]       f_sum;
  logic [rrd_pkg::ROOT_W-1:0]      s_root;
  logic signed [2:0][OW-1:0]       refl;
  logic                            degen;

  // common pipeline enable
  assign en        = !d_valid || out_tready;
  assign in_tready = en;

  // unpack input fields
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = in_tdata[i*IN_WIDTH +: IN_WIDTH];
      nrm[i] = in_tdata[(3+i)*IN_WIDTH +: IN_WIDTH];
    end
  end

  rrd_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .dir       (dir),
    .nrm       (nrm),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_sum   (f_sum)
  );

  rrd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_sum    (f_sum),
    .out_valid (s_valid),
    .out_side  (s_side),
    .out_root  (s_root)
  );

  rrd_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_side   (s_side),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_refl  (refl),
    .out_degen (degen)
  );

  // pack result item
  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      out_tdata[i*OW +: OW] = refl[i];
    end
  end

  assign out_tvalid = d_valid;
  assign out_tuser  = degen;

endmodule

// ===== rtl/rrd_checker.sv =====
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks for the reflection core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrd_checker #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic [((6*IN_WIDTH+7)/8)*8-1:0]          in_tdata,
  input logic                                     in_tvalid,
  input logic                                     in_tready,
  input logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] out_tdata,
  input logic                                     out_tuser,
  input logic                                     out_tvalid,
  input logic                                     out_tready
);

  localparam int OW  = OUT_FRAC_BITS + 2;
  localparam int LIM = 1 << OUT_FRAC_BITS;

  logic signed [OW-1:0] rx, ry, rz;

  assign rx = out_tdata[OW-1:0];
  assign ry = out_tdata[2*OW-1:OW];
  assign rz = out_tdata[3*OW-1:2*OW];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tuser))
    else $error("result changed while stalled");

  // input side only stalls when a result is stuck
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output stall");

  // degenerate results carry zero components
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> rx == 0 && ry == 0 && rz == 0)
    else $error("degenerate result with nonzero components");

  // unit vector components stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> rx <= LIM && rx >= -LIM && ry <= LIM && ry >= -LIM
                   && rz <= LIM && rz >= -LIM)
    else $error("component beyond unit magnitude");

  // pipeline is empty after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind ray_reflection_direction_core rrd_checker #(
  .IN_WIDTH      (IN_WIDTH),
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_rrd_checker (.*);
